// File: rtl/ufae_pkg.sv
package ufae_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int IHL_UNIT  = 4;
    localparam int IHL_SHIFT = $clog2(IHL_UNIT);

    // byte positions in the Ethernet header
    localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_TAG_HI  = POS_W'(16);
    localparam logic [POS_W-1:0] POS_TAG_LO  = POS_W'(17);
    localparam logic [POS_W-1:0] OFS_UNTAGGED = POS_W'(14);
    localparam logic [POS_W-1:0] OFS_TAGGED   = POS_W'(18);

    // offsets inside the network header
    localparam logic [POS_W-1:0] V4_IHL     = POS_W'(0);
    localparam logic [POS_W-1:0] V4_PROTO   = POS_W'(9);
    localparam logic [POS_W-1:0] V4_SRC     = POS_W'(12);
    localparam logic [POS_W-1:0] V4_DST     = POS_W'(16);
    localparam logic [POS_W-1:0] V4_END     = POS_W'(20);
    localparam logic [POS_W-1:0] V6_NEXT    = POS_W'(6);
    localparam logic [POS_W-1:0] V6_SRC_HI  = POS_W'(8);
    localparam logic [POS_W-1:0] V6_SRC_LO  = POS_W'(16);
    localparam logic [POS_W-1:0] V6_DST_HI  = POS_W'(24);
    localparam logic [POS_W-1:0] V6_DST_LO  = POS_W'(32);
    localparam logic [POS_W-1:0] V6_END     = POS_W'(40);
    localparam logic [POS_W-1:0] UDP_BYTES  = POS_W'(8);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;

    typedef struct packed {
        logic [255:0] data;
        logic [1:0]   kind;
    } result_t;

endpackage

// File: rtl/udp_frame_address_extractor.sv
// Parses an Ethernet frame streamed one byte per transaction (tlast on the final
// byte), skips one 802.1Q tag and, on the final byte, returns one transaction with
// the kind (none, IPv4 UDP, IPv6 UDP) in tuser and the source and destination
// addresses in tdata (all zero when there is no match). One byte is taken every
// clock while the input is not stalled; the result is registered into an output
// register backed by a skid register, so the input only stalls when both hold a
// result not yet taken. Frames longer than MAX_FRAME_BYTES are judged as if cut
// to that length.
module udp_frame_address_extractor
    import ufae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
    input  logic         s_axis_tlast,   // end_of_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,   // source_high, source_low, dest_high, dest_low
    output logic [1:0]   m_axis_tuser    // packet_kind
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [15:0]      ftype_reg, ftype_next, ftype_upd;
    logic             tagged_reg, tagged_next, tagged_upd;
    logic [5:0]       ihl_reg, ihl_next, ihl_upd;
    logic [7:0]       proto_reg, proto_next, proto_upd;
    logic [7:0]       tag_hi_reg, tag_hi_next, tag_hi_upd;
    logic [63:0]      src0_reg, src0_next, src0_upd;
    logic [63:0]      src1_reg, src1_next, src1_upd;
    logic [63:0]      dst0_reg, dst0_next, dst0_upd;
    logic [63:0]      dst1_reg, dst1_next, dst1_upd;

    logic             take;
    logic             skip_net;
    logic [POS_W-1:0] ofs;
    logic [POS_W-1:0] rel;
    logic [7:0]       b;
    logic             res_valid;
    result_t          res;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_reg, out_next;
    result_t          skid_reg, skid_next;

    assign take          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign b             = s_axis_tdata;
    assign ofs           = tagged_reg ? OFS_TAGGED : OFS_UNTAGGED;
    assign rel           = pos_reg - ofs;

    // byte capture
    always_comb
    begin
        pos_upd    = pos_reg;
        ftype_upd  = ftype_reg;
        tagged_upd = tagged_reg;
        ihl_upd    = ihl_reg;
        proto_upd  = proto_reg;
        tag_hi_upd = tag_hi_reg;
        src0_upd   = src0_reg;
        src1_upd   = src1_reg;
        dst0_upd   = dst0_reg;
        dst1_upd   = dst1_reg;
        skip_net   = 1'b0;
        if (pos_reg < POS_W'(MAX_FRAME_BYTES))
        begin
            pos_upd = pos_reg + POS_W'(1);
            if (pos_reg == POS_TYPE_HI)
            begin
                ftype_upd = {b, 8'h00};
            end
            else if (pos_reg == POS_TYPE_LO)
            begin
                ftype_upd = {ftype_reg[15:8], b};
            end
            else if (ftype_reg == TYPE_VLAN && !tagged_reg)
            begin
                skip_net = 1'b1;
                if (pos_reg == POS_TAG_HI)
                begin
                    tag_hi_upd = b;
                end
                else if (pos_reg == POS_TAG_LO)
                begin
                    ftype_upd  = {tag_hi_reg, b};
                    tagged_upd = 1'b1;
                end
            end
            if (!skip_net && pos_reg >= ofs)
            begin
                if (ftype_reg == TYPE_IPV4)
                begin
                    if (rel == V4_IHL)
                        ihl_upd = {b[3:0], IHL_SHIFT'(0)};
                    else if (rel == V4_PROTO)
                        proto_upd = b;
                    else if (rel >= V4_SRC && rel < V4_DST)
                        src1_upd = {32'h0, src1_reg[23:0], b};
                    else if (rel >= V4_DST && rel < V4_END)
                        dst1_upd = {32'h0, dst1_reg[23:0], b};
                end
                else if (ftype_reg == TYPE_IPV6)
                begin
                    if (rel == V6_NEXT)
                        proto_upd = b;
                    else if (rel >= V6_SRC_HI && rel < V6_SRC_LO)
                        src0_upd = {src0_reg[55:0], b};
                    else if (rel >= V6_SRC_LO && rel < V6_DST_HI)
                        src1_upd = {src1_reg[55:0], b};
                    else if (rel >= V6_DST_HI && rel < V6_DST_LO)
                        dst0_upd = {dst0_reg[55:0], b};
                    else if (rel >= V6_DST_LO && rel < V6_END)
                        dst1_upd = {dst1_reg[55:0], b};
                end
            end
        end
    end

    // end-of-frame verdict on the updated state
    always_comb
    begin
        logic [POS_W-1:0] ofs_upd;
        ofs_upd   = tagged_upd ? OFS_TAGGED : OFS_UNTAGGED;
        res_valid = take && s_axis_tlast;
        res.kind  = KIND_NONE;
        if (ftype_upd == TYPE_IPV4)
        begin
            if (pos_upd >= ofs_upd + V4_END && proto_upd == PROTO_UDP &&
                pos_upd >= ofs_upd + POS_W'(ihl_upd) + UDP_BYTES)
                res.kind = KIND_IPV4;
        end
        else if (ftype_upd == TYPE_IPV6)
        begin
            if (pos_upd >= ofs_upd + V6_END + UDP_BYTES && proto_upd == PROTO_UDP)
                res.kind = KIND_IPV6;
        end
        if (res.kind != KIND_NONE)
            res.data = {dst1_upd, dst0_upd, src1_upd, src0_upd};
        else
            res.data = '0;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        ftype_next  = ftype_reg;
        tagged_next = tagged_reg;
        ihl_next    = ihl_reg;
        proto_next  = proto_reg;
        tag_hi_next = tag_hi_reg;
        src0_next   = src0_reg;
        src1_next   = src1_reg;
        dst0_next   = dst0_reg;
        dst1_next   = dst1_reg;
        if (take && s_axis_tlast)
        begin
            pos_next    = '0;
            ftype_next  = '0;
            tagged_next = 1'b0;
            ihl_next    = '0;
            proto_next  = '0;
            tag_hi_next = '0;
            src0_next   = '0;
            src1_next   = '0;
            dst0_next   = '0;
            dst1_next   = '0;
        end
        else if (take)
        begin
            pos_next    = pos_upd;
            ftype_next  = ftype_upd;
            tagged_next = tagged_upd;
            ihl_next    = ihl_upd;
            proto_next  = proto_upd;
            tag_hi_next = tag_hi_upd;
            src0_next   = src0_upd;
            src1_next   = src1_upd;
            dst0_next   = dst0_upd;
            dst1_next   = dst1_upd;
        end
    end

    // output register plus skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            ftype_reg      <= '0;
            tagged_reg     <= 1'b0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            tag_hi_reg     <= '0;
            src0_reg       <= '0;
            src1_reg       <= '0;
            dst0_reg       <= '0;
            dst1_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            ftype_reg      <= ftype_next;
            tagged_reg     <= tagged_next;
            ihl_reg        <= ihl_next;
            proto_reg      <= proto_next;
            tag_hi_reg     <= tag_hi_next;
            src0_reg       <= src0_next;
            src1_reg       <= src1_next;
            dst0_reg       <= dst0_next;
            dst1_reg       <= dst1_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data;
    assign m_axis_tuser  = out_reg.kind;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position beyond frame bound");

    a_tag_after_type: assert property (@(posedge clk) disable iff (!rst_n)
        tagged_reg |-> pos_reg >= OFS_TAGGED)
        else $error("tag skipped before its ethertype was read");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_NONE) |-> m_axis_tdata == '0)
        else $error("unmatched frame carries addresses");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> pos_reg == '0)
        else $error("frame state not cleared after last byte");

endmodule
